[src/spt_pkg.sv]
package spt_pkg;

	localparam int unsigned DepthDefault = 1024;
	localparam int unsigned ValueWidth = 64;
	localparam int unsigned FieldWidth = 11;

	typedef enum logic [2:0] {
		ACT_CLEAR  = 3'd0,
		ACT_ADD    = 3'd1,
		ACT_SEARCH = 3'd2,
		ACT_FIND   = 3'd3,
		ACT_RMZERO = 3'd4,
		ACT_SORT   = 3'd5
	} action_t;

	typedef struct packed {
		logic [2:0]            action;
		logic [ValueWidth-1:0] value;
	} req_t;

	typedef struct packed {
		logic [FieldWidth-1:0] index;
		logic                  found;
		logic [FieldWidth-1:0] count;
		logic                  full_error;
	} rsp_t;

	// Request to the memory port from the sequencer.
	typedef struct packed {
		logic we;
	} mem_ctl_t;

endpackage

[src/spt_ram.sv]
module spt_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW = 10,
	parameter int unsigned DW = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/sorted_pointer_table.sv]
// Channel | Signals                         | Payload
// in      | in_valid, in_ready              | spt_pkg::req_t (action, value)
// out     | out_valid, out_ready            | spt_pkg::rsp_t (index, found, count, full_error)
// One request at a time; in_ready is low while a request is at work.
// Work per action: add/clear need no RAM read, search reads once per halving step,
// find reads up to every entry, remove zeros reads every entry, sort moves elements
// (quadratic) plus a dedupe pass over every entry; all bound by the single RAM read port.
// Reset clears the fill count and any waiting result; entries are undefined until added.
// A result waits in the output register while out_ready is low.
module sorted_pointer_table #(
	parameter int unsigned DEPTH = spt_pkg::DepthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  spt_pkg::req_t in,
	output logic          out_valid,
	input  logic          out_ready,
	output spt_pkg::rsp_t out
);
	import spt_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned VW = ValueWidth;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_RD    = 11'b00000000010,
		S_WAIT  = 11'b00000000100,
		S_FIND  = 11'b00000001000,
		S_SRCH  = 11'b00000010000,
		S_RMZ   = 11'b00000100000,
		S_INS   = 11'b00001000000,
		S_SHIFT = 11'b00010000000,
		S_DED   = 11'b00100000000,
		S_DONE  = 11'b01000000000,
		S_RKEY  = 11'b10000000000
	} state_t;

	state_t        state_q, ret_q;
	action_t       act_q;
	logic [VW-1:0] val_q, key_q, prev_q;
	logic [CW-1:0] cnt_q, rd_q, wr_q, lo_q, hi_q, i_q, j_q;
	logic [CW-1:0] res_idx_q;
	logic          hit_q, full_q;
	rsp_t          out_q;
	logic          out_valid_q;

	mem_ctl_t      ctl;
	logic [AW-1:0] waddr, raddr;
	logic [VW-1:0] wdata, rdata;
	logic [CW-1:0] mid;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	spt_ram #(.DEPTH(DEPTH), .AW(AW), .DW(VW)) u_ram (
		.clk(clk), .we(ctl.we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out       = out_q;

	// Memory port control from the sequencer state.
	always_comb begin
		ctl   = '0;
		waddr = wr_q[AW-1:0];
		wdata = val_q;
		raddr = rd_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				ctl.we = in_valid && in_ready && (in.action == ACT_ADD)
					&& (cnt_q < CW'(DEPTH));
				waddr  = cnt_q[AW-1:0];
				wdata  = in.value;
			end
			S_RMZ: begin
				ctl.we = (rdata != '0);
				wdata  = rdata;
			end
			S_DED: begin
				ctl.we = (wr_q == '0) || (prev_q != rdata);
				wdata  = rdata;
			end
			S_SHIFT: begin
				// Moves entry j-1 up to j, or drops the key at j.
				waddr  = j_q[AW-1:0];
				ctl.we = 1'b1;
				wdata  = (j_q != '0 && rdata > key_q) ? rdata : key_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						act_q     <= action_t'(in.action);
						val_q     <= in.value;
						res_idx_q <= '0;
						hit_q     <= 1'b0;
						full_q    <= 1'b0;
						rd_q      <= '0;
						wr_q      <= '0;
						lo_q      <= '0;
						hi_q      <= cnt_q;
						i_q       <= CW'(1);
						state_q   <= S_DONE;
						case (in.action)
							ACT_CLEAR: cnt_q <= '0;
							ACT_ADD: begin
								if (cnt_q < CW'(DEPTH)) cnt_q <= cnt_q + 1'b1;
								else full_q <= 1'b1;
							end
							ACT_SEARCH: state_q <= S_RD;
							ACT_FIND, ACT_RMZERO: state_q <= S_RD;
							ACT_SORT: state_q <= S_RKEY;
							default: ;
						endcase
					end
				end
				S_RD: begin
					// Issue a read; rdata is valid after S_WAIT.
					if (act_q == ACT_SEARCH) begin
						if (lo_q < hi_q) begin
							rd_q <= mid;
							ret_q <= S_SRCH;
							state_q <= S_WAIT;
						end else begin
							res_idx_q <= lo_q;
							state_q <= S_DONE;
						end
					end else if (rd_q < cnt_q) begin
						ret_q <= (act_q == ACT_FIND) ? S_FIND :
							(act_q == ACT_RMZERO) ? S_RMZ : S_DED;
						state_q <= S_WAIT;
					end else begin
						if (act_q != ACT_FIND) cnt_q <= wr_q;
						state_q <= S_DONE;
					end
				end
				S_WAIT: state_q <= ret_q;
				S_SRCH: begin
					if (val_q <= rdata) hi_q <= rd_q;
					else lo_q <= rd_q + 1'b1;
					state_q <= S_RD;
				end
				S_FIND: begin
					if (rdata == val_q) begin
						hit_q <= 1'b1;
						res_idx_q <= rd_q;
						state_q <= S_DONE;
					end else begin
						rd_q <= rd_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_RMZ: begin
					if (rdata != '0) wr_q <= wr_q + 1'b1;
					rd_q <= rd_q + 1'b1;
					state_q <= S_RD;
				end
				S_DED: begin
					if (wr_q == '0 || prev_q != rdata) begin
						wr_q <= wr_q + 1'b1;
						prev_q <= rdata;
					end
					rd_q <= rd_q + 1'b1;
					state_q <= S_RD;
				end
				S_RKEY: begin
					// Insertion sort: fetch key at i.
					if (i_q < cnt_q) begin
						rd_q <= i_q;
						j_q <= i_q;
						ret_q <= S_INS;
						state_q <= S_WAIT;
					end else begin
						rd_q <= '0;
						wr_q <= '0;
						state_q <= S_RD;
					end
				end
				S_INS: begin
					key_q <= rdata;
					rd_q <= j_q - 1'b1;
					ret_q <= S_SHIFT;
					state_q <= S_WAIT;
				end
				S_SHIFT: begin
					if (j_q != '0 && rdata > key_q) begin
						j_q <= j_q - 1'b1;
						rd_q <= j_q - CW'(2);
						state_q <= (j_q == CW'(1)) ? S_SHIFT : S_WAIT;
						ret_q <= S_SHIFT;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_RKEY;
					end
				end
				S_DONE: begin
					// The output register is always empty here, since a request
					// is only taken when no result is waiting.
					if (!out_valid_q) begin
						out_q.index      <= FieldWidth'(res_idx_q);
						out_q.found      <= hit_q;
						out_q.count      <= FieldWidth'(cnt_q);
						out_q.full_error <= full_q;
						out_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
